// ===== rtl/core/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
// Depends on nothing; every other file refers to it by scoped names.
package bba_pkg;

  localparam int POOL_UNITS = 1024;
  localparam int ADDR_W     = $clog2(POOL_UNITS);
  localparam int NODE_W     = ADDR_W + 1;
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int RAM_DEPTH  = 2 * POOL_UNITS;

  localparam int FLAG_W      = 3;
  localparam int F_TAKEN     = 0;
  localparam int F_LOW_BUSY  = 1;
  localparam int F_HIGH_BUSY = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] addr;
    logic              we;
    logic [FLAG_W-1:0] wdata;
  } ram_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_BT,
    S_A_UP_RD,
    S_A_UP_EV,
    S_F_RD,
    S_F_EV,
    S_F_UP_RD,
    S_F_UP_EV,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/bba_flag_ram.sv =====
// Node flag store: one port, registered read data, write at the same address.
// Depends on bba_pkg.
module bba_flag_ram (
  input  logic                      clk,
  input  bba_pkg::ram_req_t         req,
  output logic [bba_pkg::FLAG_W-1:0] rdata
);

  logic [bba_pkg::FLAG_W-1:0] mem [bba_pkg::RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

// ===== rtl/core/bba_seq.sv =====
// Sequencer and shared datapath: walks the node tree one level per step.
// Depends on bba_pkg; drives the flag store through a ram_req_t.
module bba_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        command,
  input  logic [bba_pkg::SIZE_W-1:0]  request_size,
  input  logic [bba_pkg::ADDR_W-1:0]  free_address,
  input  logic [bba_pkg::FLAG_W-1:0]  rdata,
  output bba_pkg::ram_req_t           req,
  output logic                        busy,
  output logic                        done,
  output logic [bba_pkg::ADDR_W-1:0]  block_address,
  output logic                        success
);

  bba_pkg::state_t state, state_next;
  logic [bba_pkg::NODE_W-1:0] node, node_next, clr, clr_next;
  logic [bba_pkg::SIZE_W-1:0] span, span_next, want, want_next, half, pmask;
  logic [bba_pkg::ADDR_W-1:0] base, base_next, addr, addr_next, res_addr, res_addr_next;
  logic upbit, upbit_next, res_ok, res_ok_next;
  logic taken, kids, fits_lower, at_start, go_high, other;

  assign half       = span >> 1;
  assign pmask      = (span << 1) - bba_pkg::SIZE_W'(1);
  assign taken      = rdata[bba_pkg::F_TAKEN];
  assign kids       = rdata[bba_pkg::F_LOW_BUSY] | rdata[bba_pkg::F_HIGH_BUSY];
  assign fits_lower = (span > bba_pkg::SIZE_W'(1)) && (want <= half);
  assign at_start   = (addr & (span[bba_pkg::ADDR_W-1:0] - bba_pkg::ADDR_W'(1))) == '0;
  assign go_high    = (addr & half[bba_pkg::ADDR_W-1:0]) != '0;
  assign other      = upbit ? rdata[bba_pkg::F_LOW_BUSY] : rdata[bba_pkg::F_HIGH_BUSY];

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::S_CLEAR:   if (clr == '1) state_next = bba_pkg::S_IDLE;
      bba_pkg::S_IDLE: begin
        if (start) begin
          if (command == bba_pkg::CMD_FREE) begin
            state_next = bba_pkg::S_F_RD;
          end else if (request_size == '0 || request_size > bba_pkg::SIZE_W'(bba_pkg::POOL_UNITS))
          begin
            state_next = bba_pkg::S_DONE;
          end else begin
            state_next = bba_pkg::S_A_RD;
          end
        end
      end
      bba_pkg::S_A_RD:    state_next = bba_pkg::S_A_EV;
      bba_pkg::S_A_EV: begin
        if (taken) state_next = bba_pkg::S_A_BT;
        else if (fits_lower) state_next = bba_pkg::S_A_RD;
        else if (kids) state_next = bba_pkg::S_A_BT;
        else if (node == bba_pkg::NODE_W'(1)) state_next = bba_pkg::S_DONE;
        else state_next = bba_pkg::S_A_UP_RD;
      end
      bba_pkg::S_A_BT: begin
        if (node == bba_pkg::NODE_W'(1)) state_next = bba_pkg::S_DONE;
        else if (!node[0]) state_next = bba_pkg::S_A_RD;
      end
      bba_pkg::S_A_UP_RD: state_next = bba_pkg::S_A_UP_EV;
      bba_pkg::S_A_UP_EV: begin
        if (node == bba_pkg::NODE_W'(1)) state_next = bba_pkg::S_DONE;
        else state_next = bba_pkg::S_A_UP_RD;
      end
      bba_pkg::S_F_RD:    state_next = bba_pkg::S_F_EV;
      bba_pkg::S_F_EV: begin
        if (taken) begin
          if (!at_start || node == bba_pkg::NODE_W'(1)) state_next = bba_pkg::S_DONE;
          else state_next = bba_pkg::S_F_UP_RD;
        end else if (span == bba_pkg::SIZE_W'(1) || !kids) begin
          state_next = bba_pkg::S_DONE;
        end else begin
          state_next = bba_pkg::S_F_RD;
        end
      end
      bba_pkg::S_F_UP_RD: state_next = bba_pkg::S_F_UP_EV;
      bba_pkg::S_F_UP_EV: begin
        if (other || node == bba_pkg::NODE_W'(1)) state_next = bba_pkg::S_DONE;
        else state_next = bba_pkg::S_F_UP_RD;
      end
      bba_pkg::S_DONE:    state_next = bba_pkg::S_IDLE;
      default:            state_next = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    node_next     = node;
    span_next     = span;
    base_next     = base;
    want_next     = want;
    addr_next     = addr;
    upbit_next    = upbit;
    res_addr_next = res_addr;
    res_ok_next   = res_ok;
    clr_next      = clr;
    req.addr      = node;
    req.we        = 1'b0;
    req.wdata     = rdata;
    case (state)
      bba_pkg::S_CLEAR: begin
        req.addr  = clr;
        req.we    = 1'b1;
        req.wdata = '0;
        clr_next  = clr + bba_pkg::NODE_W'(1);
      end
      bba_pkg::S_IDLE: begin
        node_next     = bba_pkg::NODE_W'(1);
        span_next     = bba_pkg::SIZE_W'(bba_pkg::POOL_UNITS);
        base_next     = '0;
        want_next     = request_size;
        addr_next     = free_address;
        res_addr_next = '0;
        res_ok_next   = 1'b0;
      end
      bba_pkg::S_A_EV: begin
        if (!taken && fits_lower) begin
          node_next = node << 1;
          span_next = half;
        end else if (!taken && !kids) begin
          req.we        = 1'b1;
          req.wdata     = rdata | bba_pkg::FLAG_W'(1 << bba_pkg::F_TAKEN);
          res_addr_next = base;
          res_ok_next   = 1'b1;
          upbit_next    = node[0];
          node_next     = node >> 1;
        end
      end
      bba_pkg::S_A_BT: begin
        // step to the upper sibling, or climb out of a failed upper half
        if (node != bba_pkg::NODE_W'(1)) begin
          if (!node[0]) begin
            node_next = node + bba_pkg::NODE_W'(1);
            base_next = base + span[bba_pkg::ADDR_W-1:0];
          end else begin
            node_next = node >> 1;
            span_next = span << 1;
            base_next = base & ~pmask[bba_pkg::ADDR_W-1:0];
          end
        end
      end
      bba_pkg::S_A_UP_EV: begin
        req.we     = 1'b1;
        req.wdata  = rdata | (upbit ? bba_pkg::FLAG_W'(1 << bba_pkg::F_HIGH_BUSY)
                                    : bba_pkg::FLAG_W'(1 << bba_pkg::F_LOW_BUSY));
        upbit_next = node[0];
        node_next  = node >> 1;
      end
      bba_pkg::S_F_EV: begin
        if (taken) begin
          if (at_start) begin
            req.we      = 1'b1;
            req.wdata   = rdata & ~bba_pkg::FLAG_W'(1 << bba_pkg::F_TAKEN);
            res_ok_next = 1'b1;
            upbit_next  = node[0];
            node_next   = node >> 1;
          end
        end else if (span != bba_pkg::SIZE_W'(1) && kids) begin
          node_next = {node[bba_pkg::NODE_W-2:0], go_high};
          span_next = half;
        end
      end
      bba_pkg::S_F_UP_EV: begin
        req.we     = 1'b1;
        req.wdata  = rdata & ~(upbit ? bba_pkg::FLAG_W'(1 << bba_pkg::F_HIGH_BUSY)
                                     : bba_pkg::FLAG_W'(1 << bba_pkg::F_LOW_BUSY));
        upbit_next = node[0];
        node_next  = node >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      clr   <= clr_next;
    end
    node     <= node_next;
    span     <= span_next;
    base     <= base_next;
    want     <= want_next;
    addr     <= addr_next;
    upbit    <= upbit_next;
    res_addr <= res_addr_next;
    res_ok   <= res_ok_next;
  end

  assign busy          = state != bba_pkg::S_IDLE;
  assign done          = state == bba_pkg::S_DONE;
  assign block_address = res_addr;
  assign success       = res_ok;

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    state == bba_pkg::S_DONE |=> state == bba_pkg::S_IDLE) else $error("done not followed by idle");
  a_taken_bt: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_A_EV && taken) |=> state == bba_pkg::S_A_BT)
    else $error("descent passed a taken node");
  a_span_hot: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_A_RD || state == bba_pkg::S_F_RD) |-> $onehot(span))
    else $error("span lost its single bit");
  a_node_live: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_A_RD || state == bba_pkg::S_F_RD) |-> node != '0)
    else $error("walk left the tree");

endmodule

// ===== rtl/core/buddy_block_allocator_unit.sv =====
// Top level of the buddy block allocator: sequencer plus node flag store.
// Depends on bba_pkg, bba_flag_ram and bba_seq.
//
//  channel   | handshake         | payload
//  ----------+-------------------+-------------------------------------------
//  request   | start & !busy     | command, request_size, free_address
//  result    | done (one cycle)  | block_address, success
//
// The time an item takes grows with the tree levels it visits; an allocate that
// backtracks through the tree visits far more nodes than a free or a first-fit
// allocate. The single flag store port sets the pace: each node visit is a read
// followed by an evaluate step, and every update is written in the evaluate step.
// After reset every flag store entry is swept clear with busy high.
// The result strobe lasts one cycle and cannot be held off.
module buddy_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command,
  input  logic [bba_pkg::SIZE_W-1:0]  request_size,
  input  logic [bba_pkg::ADDR_W-1:0]  free_address,
  output logic                        done,
  output logic [bba_pkg::ADDR_W-1:0]  block_address,
  output logic                        success
);

  bba_pkg::ram_req_t          req;
  logic [bba_pkg::FLAG_W-1:0] rdata;

  bba_flag_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  bba_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .command       (command),
    .request_size  (request_size),
    .free_address  (free_address),
    .rdata         (rdata),
    .req           (req),
    .busy          (busy),
    .done          (done),
    .block_address (block_address),
    .success       (success)
  );

endmodule

// ===== dv/buddy_block_allocator_unit_test.sv =====
// Self-checking testbench for the buddy block allocator unit.
// Depends on bba_pkg and the RTL under rtl/core; needs no files or arguments.
module buddy_block_allocator_unit_test;

  localparam int NODES = 2 * bba_pkg::POOL_UNITS;
  localparam int BIT_TAKEN = 1;
  localparam int BIT_LOW = 2;
  localparam int BIT_HIGH = 4;

  typedef struct {
    logic [bba_pkg::ADDR_W-1:0] block_address;
    logic                       success;
  } grant_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       command = bba_pkg::CMD_ALLOC;
  logic [bba_pkg::SIZE_W-1:0] request_size = '0;
  logic [bba_pkg::ADDR_W-1:0] free_address = '0;
  logic                       done;
  logic [bba_pkg::ADDR_W-1:0] block_address;
  logic                       success;

  bit [2:0] tree_flags [NODES];
  grant_t   grants_due [$];
  int       live_blocks [$];
  int       errors = 0;
  int       send_idle_pct = 0;

  buddy_block_allocator_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .request_size(request_size), .free_address(free_address), .done(done),
    .block_address(block_address), .success(success)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit place_block(int node, int span, int base, int want,
                                     ref int where);
    int half;
    half = span / 2;
    if (tree_flags[node] & BIT_TAKEN) return 0;
    if (want > span) return 0;
    if (span > 1 && want <= half) begin
      if (place_block(2 * node, half, base, want, where)) begin
        tree_flags[node] |= BIT_LOW;
        return 1;
      end
      if (place_block(2 * node + 1, half, base + half, want, where)) begin
        tree_flags[node] |= BIT_HIGH;
        return 1;
      end
      return 0;
    end
    if (tree_flags[node] & (BIT_LOW | BIT_HIGH)) return 0;
    tree_flags[node] |= BIT_TAKEN;
    where = base;
    return 1;
  endfunction

  // 0 nothing released, 1 released and subtree empty, 2 released but still busy
  function automatic int release_block(int node, int span, int base, int addr);
    int half;
    int r;
    bit [2:0] f;
    half = span / 2;
    f = tree_flags[node];
    if (f & BIT_TAKEN) begin
      if (addr != base) return 0;
      tree_flags[node] = f & ~3'(BIT_TAKEN);
      return 1;
    end
    if (span <= 1 || (f & (BIT_LOW | BIT_HIGH)) == 0) return 0;
    if (addr >= base + half) begin
      r = release_block(2 * node + 1, half, base + half, addr);
      if (r != 1) return r;
      tree_flags[node] &= ~3'(BIT_HIGH);
      return (tree_flags[node] & BIT_LOW) ? 2 : 1;
    end
    r = release_block(2 * node, half, base, addr);
    if (r != 1) return r;
    tree_flags[node] &= ~3'(BIT_LOW);
    return (tree_flags[node] & BIT_HIGH) ? 2 : 1;
  endfunction

  function automatic void predict_grant(logic cmd, int want, int addr);
    grant_t g;
    int where;
    bit ok;
    where = 0;
    ok = 0;
    if (cmd == bba_pkg::CMD_ALLOC) begin
      if (want != 0 && want <= bba_pkg::POOL_UNITS)
        ok = place_block(1, bba_pkg::POOL_UNITS, 0, want, where);
      if (!ok) where = 0;
      else live_blocks.push_back(where);
    end else begin
      if (addr < bba_pkg::POOL_UNITS)
        ok = release_block(1, bba_pkg::POOL_UNITS, 0, addr) != 0;
      where = 0;
    end
    g.block_address = where[bba_pkg::ADDR_W-1:0];
    g.success = ok;
    grants_due.push_back(g);
  endfunction

  task automatic send_request(logic cmd, int want, int addr);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    command <= cmd;
    request_size <= want[bba_pkg::SIZE_W-1:0];
    free_address <= addr[bba_pkg::ADDR_W-1:0];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    predict_grant(cmd, want, addr);
    start <= 1'b0;
    // the block is busy on the next edge anyway; step past it
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    grant_t g;
    if (!rst && done) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result: block_address %0d success %0b", block_address, success);
        errors++;
      end else begin
        g = grants_due.pop_front();
        if (block_address !== g.block_address) begin
          $error("block_address expected %0d actual %0d", g.block_address, block_address);
          errors++;
        end
        if (success !== g.success) begin
          $error("success expected %0b actual %0b", g.success, success);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  task automatic free_random_live();
    int k;
    int a;
    k = $urandom_range(live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    send_request(bba_pkg::CMD_FREE, $urandom_range(2047), a);
  endtask

  task automatic test_directed();
    int sizes [] = '{0, 1, 1, 2, 3, 1024, 1025, 2047, 512, 7, 256};
    foreach (sizes[i]) send_request(bba_pkg::CMD_ALLOC, sizes[i], $urandom_range(1023));
    send_request(bba_pkg::CMD_FREE, 0, 5);     // inside a taken block
    send_request(bba_pkg::CMD_FREE, 0, 1023);  // inside a taken block
    send_request(bba_pkg::CMD_FREE, 5, 0);
    send_request(bba_pkg::CMD_FREE, 5, 0);     // now free already
    live_blocks.delete();
    for (int a = 0; a < bba_pkg::POOL_UNITS; a += 256) send_request(bba_pkg::CMD_FREE, 0, a);
    for (int a = 0; a < 16; a++) send_request(bba_pkg::CMD_FREE, 0, a);
    send_request(bba_pkg::CMD_ALLOC, 1024, 0);  // whole pool
    send_request(bba_pkg::CMD_ALLOC, 1, 0);     // blocked by taken root
    send_request(bba_pkg::CMD_FREE, 0, 0);
    live_blocks.delete();
  endtask

  task automatic test_random(int count, int pct);
    int r;
    send_idle_pct = pct;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 45) send_request(bba_pkg::CMD_ALLOC, $urandom_range(1, 64) >> $urandom_range(5),
                               $urandom_range(1023));
      else if (r < 52) send_request(bba_pkg::CMD_ALLOC, $urandom_range(2047),
                                    $urandom_range(1023));
      else if (r < 88 && live_blocks.size() > 0) free_random_live();
      else send_request(bba_pkg::CMD_FREE, $urandom_range(2047), $urandom_range(1023));
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(430, 30);
    test_random(430, 47);
    test_random(430, 0);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("buddy_block_allocator_unit_test: done, clean");
    else $display("buddy_block_allocator_unit_test: done, errors");
    $finish;
  end

  initial begin
    #300000000;
    $display("buddy_block_allocator_unit_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_flag_ram.sv
rtl/core/bba_seq.sv
rtl/core/buddy_block_allocator_unit.sv
dv/buddy_block_allocator_unit_test.sv
